>>> hw/rtl/csdet_pkg.sv
// Package: shared types and codes for the charset detector.
`timescale 1ns / 1ps
`default_nettype none
package csdet_pkg;

    localparam int CharsetW = 2;
    localparam int CountW   = 16;

    localparam logic [CharsetW-1:0] CS_ASCII = 2'd0;
    localparam logic [CharsetW-1:0] CS_UTF8  = 2'd1;
    localparam logic [CharsetW-1:0] CS_EUC   = 2'd2;
    localparam logic [CharsetW-1:0] CS_SJIS  = 2'd3;

    localparam logic [CountW-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [CharsetW-1:0] charset;
        logic                any_high;
        logic                utf8_ok;
        logic [CountW-1:0]   sjis_pairs;
        logic [CountW-1:0]   euc_pairs;
    } t_result;

endpackage
`default_nettype wire

>>> hw/rtl/csdet_if.sv
// Interfaces: byte input channel and verdict output channel.
`timescale 1ns / 1ps
`default_nettype none
interface csdet_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface csdet_out_if;
    import csdet_pkg::*;
    logic                valid;
    logic                ready;
    logic [CharsetW-1:0] charset;
    logic                any_high;
    logic                utf8_ok;
    logic [CountW-1:0]   sjis_pairs;
    logic [CountW-1:0]   euc_pairs;

    modport source (output valid, output charset, output any_high, output utf8_ok,
                    output sjis_pairs, output euc_pairs, input ready);
    modport sink   (input valid, input charset, input any_high, input utf8_ok,
                    input sjis_pairs, input euc_pairs, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/charset_detector_utf8_sjis_euc_unit.sv
// Charset detector: UTF-8 check plus SJIS / EUC-JP pair counting, one byte a cycle.
//
// Usage:
//   i_in  carries one buffer byte per transaction, last_byte set on the final byte.
//   o_out carries one verdict per buffer: charset, any_high, utf8_ok and the two
//   saturating 16-bit pair counts.
// Throughput: one byte per cycle while i_in.ready is high; the per-byte update is
//   combinational: a few range compares and two saturating increments.
// Output: the verdict is registered; the spare slot takes it while o_out is busy.
// Stall: a result register plus one spare result slot sit between the channels, so
//   bytes keep flowing while a verdict waits; i_in.ready drops only once both slots
//   hold undelivered verdicts, and rises again when o_out takes one.
// Reset: i_rst_n (synchronous, active low) drops both result slots and returns the
//   scan state to the start of a buffer. After each verdict the scan state also
//   returns to that start, so the next byte opens a new buffer.
`timescale 1ns / 1ps
`default_nettype none
module charset_detector_utf8_sjis_euc_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    csdet_in_if.sink     i_in,
    csdet_out_if.source  o_out
);
    import csdet_pkg::*;

    // scan state
    logic              r_seen_high, n_seen_high;
    logic              r_utf8_good, n_utf8_good;
    logic [1:0]        r_pending,   n_pending;
    logic [7:0]        r_prev_byte;
    logic              r_have_prev;
    logic [CountW-1:0] r_sjis_cnt,  n_sjis_cnt;
    logic [CountW-1:0] r_euc_cnt,   n_euc_cnt;

    // result slots
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    logic    w_accept;
    logic    w_push;
    logic    w_pop;
    logic    w_cont;
    logic    w_sjis_hit;
    logic    w_euc_hit;
    logic    w_good_final;
    t_result w_result;
    logic [7:0] w_c;

    assign w_c      = i_in.data_byte;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_push   = w_accept && i_in.last_byte;
    assign w_pop    = r_out_valid && o_out.ready;
    assign w_cont   = (w_c[7:6] == 2'b10);

    assign i_in.ready = !r_skid_valid;

    always_comb begin
        n_seen_high = r_seen_high | w_c[7];
        n_utf8_good = r_utf8_good;
        n_pending   = r_pending;
        if (r_pending != 2'd0) begin
            if (w_cont) begin
                n_pending = r_pending - 2'd1;
            end else begin
                n_utf8_good = 1'b0;
                n_pending   = 2'd0;
            end
        end else if (w_c[7]) begin
            if (w_c[7:5] == 3'b110) begin
                n_pending = 2'd1;
            end else if (w_c[7:4] == 4'b1110) begin
                n_pending = 2'd2;
            end else if (w_c[7:3] == 5'b11110) begin
                n_pending = 2'd3;
            end else begin
                n_utf8_good = 1'b0;
            end
        end
    end

    always_comb begin
        w_sjis_hit = r_have_prev
            && (((r_prev_byte >= 8'h81) && (r_prev_byte <= 8'h9F))
                || ((r_prev_byte >= 8'hE0) && (r_prev_byte <= 8'hFC)))
            && (((w_c >= 8'h40) && (w_c <= 8'h7E))
                || ((w_c >= 8'h80) && (w_c <= 8'hFC)));
        w_euc_hit = r_have_prev
            && (r_prev_byte >= 8'hA1) && (r_prev_byte <= 8'hFE)
            && (w_c >= 8'hA1) && (w_c <= 8'hFE);
        n_sjis_cnt = r_sjis_cnt;
        n_euc_cnt  = r_euc_cnt;
        if (w_sjis_hit && (r_sjis_cnt != COUNT_MAX)) begin
            n_sjis_cnt = r_sjis_cnt + 1'b1;
        end
        if (w_euc_hit && (r_euc_cnt != COUNT_MAX)) begin
            n_euc_cnt = r_euc_cnt + 1'b1;
        end
    end

    // an unfinished sequence at the final byte fails the check
    assign w_good_final = n_utf8_good && (n_pending == 2'd0);

    always_comb begin
        w_result.any_high   = n_seen_high;
        w_result.utf8_ok    = w_good_final;
        w_result.sjis_pairs = n_sjis_cnt;
        w_result.euc_pairs  = n_euc_cnt;
        if (!n_seen_high) begin
            w_result.charset = CS_ASCII;
        end else if (w_good_final) begin
            w_result.charset = CS_UTF8;
        end else if (n_euc_cnt > n_sjis_cnt) begin
            w_result.charset = CS_EUC;
        end else begin
            w_result.charset = CS_SJIS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_push) begin
            r_seen_high <= 1'b0;
            r_utf8_good <= 1'b1;
            r_pending   <= 2'd0;
            r_prev_byte <= 8'h00;
            r_have_prev <= 1'b0;
            r_sjis_cnt  <= '0;
            r_euc_cnt   <= '0;
        end else if (w_accept) begin
            r_seen_high <= n_seen_high;
            r_utf8_good <= n_utf8_good;
            r_pending   <= n_pending;
            r_prev_byte <= w_c;
            r_have_prev <= 1'b1;
            r_sjis_cnt  <= n_sjis_cnt;
            r_euc_cnt   <= n_euc_cnt;
        end
    end

    // ready is low while the spare slot is full, so a push never meets a full skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_push) begin
                r_out <= w_result;
            end
        end else if (w_push) begin
            r_skid <= w_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.charset    = r_out.charset;
    assign o_out.any_high   = r_out.any_high;
    assign o_out.utf8_ok    = r_out.utf8_ok;
    assign o_out.sjis_pairs = r_out.sjis_pairs;
    assign o_out.euc_pairs  = r_out.euc_pairs;

endmodule
`default_nettype wire

>>> hw/rtl/csdet_chk.sv
// Checker: port-level assertions on the charset detector verdicts, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module csdet_chk (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [csdet_pkg::CharsetW-1:0] i_charset,
    input wire                          i_any_high,
    input wire                          i_utf8_ok,
    input wire [csdet_pkg::CountW-1:0]  i_sjis_pairs,
    input wire [csdet_pkg::CountW-1:0]  i_euc_pairs
);
    import csdet_pkg::*;

    // a stalled verdict holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_charset)
            && $stable(i_sjis_pairs) && $stable(i_euc_pairs)))
        else $error("stalled verdict changed");

    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_charset == CS_ASCII) == !i_any_high))
        else $error("ascii verdict disagrees with any_high");

    a_utf8: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_any_high) |-> ((i_charset == CS_UTF8) == i_utf8_ok))
        else $error("utf8 verdict disagrees with utf8_ok");

    a_ascii_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_any_high) |-> i_utf8_ok)
        else $error("all-ascii buffer failed the utf8 check");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("verdict valid right after reset");

endmodule

bind charset_detector_utf8_sjis_euc_unit csdet_chk u_csdet_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_charset    (o_out.charset),
    .i_any_high   (o_out.any_high),
    .i_utf8_ok    (o_out.utf8_ok),
    .i_sjis_pairs (o_out.sjis_pairs),
    .i_euc_pairs  (o_out.euc_pairs)
);
`default_nettype wire

>>> bench/tb.sv
// Testbench for the charset detector: directed and random buffers checked against a predictor.
`timescale 1ns / 1ps
module tb;
    import csdet_pkg::*;

    typedef logic [7:0] byte_t;

    localparam int IdleLimit   = 1000;
    localparam int RandomBytes = 420;
    localparam int ShownMax    = 10;

    logic i_clk;
    logic i_rst_n;

    csdet_in_if  byte_ch ();
    csdet_out_if verdict_ch ();

    charset_detector_utf8_sjis_euc_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (verdict_ch)
    );

    // scan state of the predictor
    bit               seen_high;
    bit               utf8_good;
    int unsigned      cont_left;
    byte_t            prev_byte;
    bit               have_prev;
    logic [CountW-1:0] sjis_cnt;
    logic [CountW-1:0] euc_cnt;

    t_result verdict_q[$];
    int      fail_cnt;
    int      shown_cnt;
    int      idle_cycles = 0;
    bit      idle_on;
    int      stall_left = 0;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    task automatic clear_scan();
        seen_high = 1'b0;
        utf8_good = 1'b1;
        cont_left = 0;
        prev_byte = '0;
        have_prev = 1'b0;
        sjis_cnt  = '0;
        euc_cnt   = '0;
    endtask

    // update scan state for one byte; on the final byte queue the expected verdict
    task automatic detect_byte(input byte_t c, input bit last);
        bit      sj_lead;
        bit      sj_trail;
        bit      euc_hit;
        t_result v;
        if (c >= 8'h80) seen_high = 1'b1;
        if (cont_left != 0) begin
            if (c[7:6] == 2'b10) begin
                cont_left = cont_left - 1;
            end else begin
                utf8_good = 1'b0;
                cont_left = 0;
            end
        end else if (c >= 8'h80) begin
            if (c[7:5] == 3'b110) cont_left = 1;
            else if (c[7:4] == 4'b1110) cont_left = 2;
            else if (c[7:3] == 5'b11110) cont_left = 3;
            else utf8_good = 1'b0;
        end
        if (have_prev) begin
            sj_lead  = (prev_byte >= 8'h81 && prev_byte <= 8'h9F) ||
                       (prev_byte >= 8'hE0 && prev_byte <= 8'hFC);
            sj_trail = (c >= 8'h40 && c <= 8'h7E) || (c >= 8'h80 && c <= 8'hFC);
            euc_hit  = (prev_byte >= 8'hA1 && prev_byte <= 8'hFE) &&
                       (c >= 8'hA1 && c <= 8'hFE);
            if (sj_lead && sj_trail && sjis_cnt != COUNT_MAX) sjis_cnt = sjis_cnt + 1'b1;
            if (euc_hit && euc_cnt != COUNT_MAX) euc_cnt = euc_cnt + 1'b1;
        end
        prev_byte = c;
        have_prev = 1'b1;
        if (last) begin
            if (cont_left != 0) utf8_good = 1'b0;
            if (!seen_high) v.charset = CS_ASCII;
            else if (utf8_good) v.charset = CS_UTF8;
            else if (euc_cnt > sjis_cnt) v.charset = CS_EUC;
            else v.charset = CS_SJIS;
            v.any_high   = seen_high;
            v.utf8_ok    = utf8_good;
            v.sjis_pairs = sjis_cnt;
            v.euc_pairs  = euc_cnt;
            verdict_q.push_back(v);
            clear_scan();
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one byte transaction; called at a rising edge, returns at the edge of acceptance
    task automatic send_byte(input byte_t c, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= c;
        byte_ch.last_byte <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        detect_byte(c, last);
    endtask

    task automatic send_text(input byte_t text[$]);
        foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    endtask

    task automatic test_ascii();
        send_text('{8'h00, 8'h7F});
        send_text('{8'h3F});
    endtask

    task automatic test_utf8_valid();
        send_text('{8'hC3, 8'hA9});
        // four-byte sequence closed by the final byte
        send_text('{8'hF0, 8'h9F, 8'h98, 8'h80});
        // overlong form and F5 lead pass the class check
        send_text('{8'hC0, 8'h80, 8'hF5, 8'h80, 8'h80, 8'h80});
    endtask

    task automatic test_utf8_errors();
        send_text('{8'hC3, 8'h41, 8'hC3, 8'hA9});  // error sticks
        send_text('{8'hE3, 8'h81});                // unfinished at end
        send_text('{8'h80});
        send_text('{8'hF8});
    endtask

    task automatic test_pair_counts();
        send_text('{8'hFE, 8'hA1});
        send_text('{8'h9F, 8'h40, 8'hFC, 8'h7E});
        send_text('{8'hE0, 8'hE0});                // tie goes to SJIS
    endtask

    task automatic test_random_buffers();
        byte_t text[$];
        int    sent;
        int    chunks;
        int    n;
        sent = 0;
        while (sent < RandomBytes) begin
            text.delete();
            chunks = $urandom_range(1, 5);
            repeat (chunks) begin
                case ($urandom_range(0, 9))
                    0, 1: repeat ($urandom_range(1, 3))
                        text.push_back(byte_t'($urandom_range(0, 8'h7F)));
                    2, 3, 4: begin
                        n = $urandom_range(1, 4);
                        case (n)
                            1: text.push_back(byte_t'($urandom_range(0, 8'h7F)));
                            2: text.push_back(8'hC0 | byte_t'($urandom_range(0, 8'h1F)));
                            3: text.push_back(8'hE0 | byte_t'($urandom_range(0, 8'h0F)));
                            default: text.push_back(8'hF0 | byte_t'($urandom_range(0, 8'h07)));
                        endcase
                        repeat (n - 1) text.push_back(8'h80 | byte_t'($urandom_range(0, 8'h3F)));
                    end
                    5, 6: begin
                        text.push_back(byte_t'($urandom_range(0, 1)
                                               ? $urandom_range(8'h81, 8'h9F)
                                               : $urandom_range(8'hE0, 8'hFC)));
                        text.push_back(byte_t'($urandom_range(0, 1)
                                               ? $urandom_range(8'h40, 8'h7E)
                                               : $urandom_range(8'h80, 8'hFC)));
                    end
                    7: repeat (2) text.push_back(byte_t'($urandom_range(8'hA1, 8'hFE)));
                    default: repeat ($urandom_range(1, 4))
                        text.push_back(byte_t'($urandom_range(0, 255)));
                endcase
            end
            // now and then cut the buffer short to leave a sequence open
            if (text.size() > 1 && $urandom_range(0, 7) == 0) void'(text.pop_back());
            send_text(text);
            sent += text.size();
        end
    endtask

    // output side: random stalls, short mostly, now and then long
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            verdict_ch.ready <= 1'b1;
            stall_left       <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) < 5) begin
            verdict_ch.ready <= 1'b1;
            stall_left       <= $urandom_range(0, 8);
        end else begin
            verdict_ch.ready <= 1'b0;
            stall_left       <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(0, 3);
        end
    end

    // verdict checker
    always @(posedge i_clk) begin
        t_result exp_v;
        t_result got_v;
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            got_v.charset    = verdict_ch.charset;
            got_v.any_high   = verdict_ch.any_high;
            got_v.utf8_ok    = verdict_ch.utf8_ok;
            got_v.sjis_pairs = verdict_ch.sjis_pairs;
            got_v.euc_pairs  = verdict_ch.euc_pairs;
            if (verdict_q.size() == 0) begin
                fail_cnt++;
                if (shown_cnt < ShownMax) begin
                    shown_cnt++;
                    $display("%0t: unexpected verdict %p", $realtime, got_v);
                end
            end else begin
                exp_v = verdict_q.pop_front();
                if (got_v.charset !== exp_v.charset || got_v.any_high !== exp_v.any_high ||
                    got_v.utf8_ok !== exp_v.utf8_ok ||
                    got_v.sjis_pairs !== exp_v.sjis_pairs ||
                    got_v.euc_pairs !== exp_v.euc_pairs) begin
                    fail_cnt++;
                    if (shown_cnt < ShownMax) begin
                        shown_cnt++;
                        $display("%0t: verdict mismatch expected %p actual %p",
                                 $realtime, exp_v, got_v);
                    end
                end
            end
        end
    end

    // watchdog: cycles without any transaction on either channel
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        fail_cnt          = 0;
        shown_cnt         = 0;
        idle_on           = 1'b1;
        clear_scan();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii();
        test_utf8_valid();
        test_utf8_errors();
        test_pair_counts();
        test_random_buffers();

        byte_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
